// File: src/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
package lir_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int STEP_W           = 21;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MAX_UPSAMPLE_DEF = 8;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;

  // Queue entry: one input sample, tagged by the front end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       first;
  } item_t;

  // One interpolation job handed from the sequencer to the datapath.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0]        mag;
    logic                       neg;
    logic                       last_of_run;
    logic                       block_done;
  } op_t;

endpackage

// File: src/lir_front.sv
// Input front end: takes input transfers and tags the first sample of each block.
module lir_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_sample,
  input  logic                          end_of_input,
  input  logic                          q_full,
  output logic                          q_push,
  output lir_pkg::item_t                q_item
);
  import lir_pkg::*;

  logic block_start;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.sample = in_sample;
    q_item.last   = end_of_input;
    q_item.first  = block_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_start <= 1'b1;
    end else if (q_push) begin
      block_start <= end_of_input;
    end
  end

endmodule

// File: src/lir_queue.sv
// Small FIFO between the front end and the sequencer.
module lir_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lir_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output lir_pkg::item_t rd_item
);
  import lir_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign valid   = (count != '0);
  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_item = mem[rd_ptr];
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/lir_back.sv
// Sequencer: walks the phase across intervals; at most one job per cycle, stalled by take.
module lir_back #(
  parameter int FRAC_BITS    = lir_pkg::FRAC_BITS_DEF,
  parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [lir_pkg::STEP_W-1:0]  cfg_data,
  input  logic                        q_valid,
  input  lir_pkg::item_t              q_item,
  output logic                        q_pop,
  input  logic                        take,
  output logic                        op_valid,
  output lir_pkg::op_t                op,
  output logic [FRAC_BITS-1:0]        op_frac
);
  import lir_pkg::*;

  localparam int SW    = (FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W;
  localparam int PW    = SW + 1;
  localparam int CW    = $clog2(MAX_UPSAMPLE);
  localparam logic [PW-1:0] ONE      = PW'(1) << FRAC_BITS;
  localparam int            STEP_MIN = ((1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_UPSAMPLE - 1);

  typedef enum logic {INTERP, TAIL} mode_t;

  logic [STEP_W-1:0]          phase_step;
  mode_t                      mode, mode_next;
  logic signed [SAMPLE_W-1:0] prev, prev_next;
  logic [PW-1:0]              phase, phase_next;
  logic [CW-1:0]              cnt, cnt_next;

  logic [SW-1:0]              step;
  logic [PW-1:0]              nphase;
  logic [PW-1:0]              after;
  logic [PW-1:0]              rem;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          diff_abs;
  logic                       run_end;

  always_comb begin
    step = (SW'(phase_step) < SW'(STEP_MIN)) ? SW'(STEP_MIN) : SW'(phase_step);
    nphase   = phase + {1'b0, step};
    after    = nphase - ONE;
    rem      = phase - ONE;
    diff     = {q_item.sample[SAMPLE_W-1], q_item.sample} - {prev[SAMPLE_W-1], prev};
    diff_abs = diff[SAMPLE_W] ? -diff : diff;
    run_end  = (nphase >= ONE) || (cnt == CNT_LAST);
  end

  always_comb begin
    mode_next  = mode;
    prev_next  = prev;
    phase_next = phase;
    cnt_next   = cnt;
    q_pop      = 1'b0;
    op_valid   = 1'b0;
    op.a           = prev;
    op.mag         = diff_abs[SAMPLE_W-1:0];
    op.neg         = diff[SAMPLE_W];
    op.last_of_run = 1'b0;
    op.block_done  = 1'b0;
    op_frac        = phase[FRAC_BITS-1:0];

    if (q_valid && take) begin
      case (mode)
        INTERP: begin
          if (q_item.first) begin
            prev_next  = q_item.sample;
            phase_next = '0;
            cnt_next   = '0;
            if (q_item.last) begin
              mode_next = TAIL;
            end else begin
              q_pop = 1'b1;
            end
          end else if (phase < ONE) begin
            op_valid = 1'b1;
            if (run_end) begin
              prev_next = q_item.sample;
              cnt_next  = '0;
              if (q_item.last && (after < ONE)) begin
                // tail follows: the run does not end here
                mode_next  = TAIL;
                phase_next = after;
              end else if (q_item.last) begin
                op.last_of_run = 1'b1;
                op.block_done  = 1'b1;
                q_pop          = 1'b1;
                prev_next      = '0;
                phase_next     = '0;
              end else begin
                op.last_of_run = 1'b1;
                q_pop          = 1'b1;
                phase_next     = after;
              end
            end else begin
              phase_next = nphase;
              cnt_next   = cnt + 1'b1;
            end
          end else begin
            // interval skipped when downsampling
            prev_next  = q_item.sample;
            phase_next = rem;
            if (q_item.last && (rem < ONE)) begin
              mode_next = TAIL;
            end else if (q_item.last) begin
              q_pop      = 1'b1;
              prev_next  = '0;
              phase_next = '0;
            end else begin
              q_pop = 1'b1;
            end
          end
        end
        TAIL: begin
          op_valid = 1'b1;
          op.mag   = '0;
          op.neg   = 1'b0;
          if (run_end) begin
            op.last_of_run = 1'b1;
            op.block_done  = 1'b1;
            q_pop          = 1'b1;
            mode_next      = INTERP;
            prev_next      = '0;
            phase_next     = '0;
            cnt_next       = '0;
          end else begin
            phase_next = nphase;
            cnt_next   = cnt + 1'b1;
          end
        end
        default: begin
          mode_next = INTERP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
      mode       <= INTERP;
      prev       <= '0;
      phase      <= '0;
      cnt        <= '0;
    end else begin
      if (cfg_write) begin
        phase_step <= cfg_data;
      end
      mode  <= mode_next;
      prev  <= prev_next;
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// File: src/lir_lerp.sv
// Interpolation datapath: operand stage, multiply stage and output register.
module lir_lerp #(
  parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  output logic                  take,
  input  logic                  op_valid,
  input  lir_pkg::op_t          op,
  input  logic [FRAC_BITS-1:0]  op_frac,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_sample,
  output logic                  last_of_run,
  output logic                  block_done
);
  import lir_pkg::*;

  localparam int PROD_W = SAMPLE_W + FRAC_BITS;

  logic                       s1_valid;
  op_t                        s1_op;
  logic [FRAC_BITS-1:0]       s1_frac;

  logic                       s2_valid;
  logic signed [SAMPLE_W-1:0] s2_a;
  logic                       s2_neg;
  logic                       s2_lor;
  logic                       s2_bd;
  logic [PROD_W-1:0]          s2_prod;

  logic [SAMPLE_W-1:0]        part;
  logic signed [SAMPLE_W:0]   result;

  // whole pipe moves together, held while the output waits
  assign take = !out_valid || out_ready;

  always_comb begin
    part = s2_prod[PROD_W-1:FRAC_BITS];
    if (s2_neg) begin
      result = {s2_a[SAMPLE_W-1], s2_a} - {1'b0, part};
    end else begin
      result = {s2_a[SAMPLE_W-1], s2_a} + {1'b0, part};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (take) begin
      s1_valid  <= op_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op       <= op;
      s1_frac     <= op_frac;
      s2_a        <= s1_op.a;
      s2_neg      <= s1_op.neg;
      s2_lor      <= s1_op.last_of_run;
      s2_bd       <= s1_op.block_done;
      s2_prod     <= PROD_W'(s1_op.mag) * PROD_W'(s1_frac);
      out_sample  <= result[SAMPLE_W-1:0];
      last_of_run <= s2_lor;
      block_done  <= s2_bd;
    end
  end

endmodule

// File: src/linear_interp_resampler.sv
// Linear interpolation sample-rate converter: 16-bit signed audio, Q phase stepping.
// Path: an input transfer is written into the queue; the sequencer reads it there and
// issues jobs through the operand stage, multiply stage and output register to out_valid.
// Throughput: one result is issued per cycle while out_ready does not hold the pipe, at
// most MAX_UPSAMPLE per interval plus MAX_UPSAMPLE tail results; a block's first sample
// or a skipped interval yields no interpolated result. The queue takes inputs until full.
// Reset: synchronous; clears queue, pipeline and phase, and restores phase_step to 65536 (1.0 at FRAC_BITS 16).
module linear_interp_resampler #(
  parameter int FRAC_BITS    = lir_pkg::FRAC_BITS_DEF,
  parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [lir_pkg::STEP_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [15:0]         in_sample,
  input  logic                       end_of_input,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [15:0]         out_sample,
  output logic                       last_of_run,
  output logic                       block_done
);
  import lir_pkg::*;

  logic                 q_full;
  logic                 q_push;
  item_t                q_wr_item;
  logic                 q_valid;
  logic                 q_pop;
  item_t                q_rd_item;
  logic                 take;
  logic                 op_valid;
  op_t                  op;
  logic [FRAC_BITS-1:0] op_frac;

  lir_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_wr_item)
  );

  lir_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_item (q_rd_item)
  );

  lir_back #(
    .FRAC_BITS    (FRAC_BITS),
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_rd_item),
    .q_pop     (q_pop),
    .take      (take),
    .op_valid  (op_valid),
    .op        (op),
    .op_frac   (op_frac)
  );

  lir_lerp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lerp (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .op_valid    (op_valid),
    .op          (op),
    .op_frac     (op_frac),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .last_of_run (last_of_run),
    .block_done  (block_done)
  );

endmodule
